[hdl/thpt_pkg.sv]
package thpt_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PRUNE,
		ST_UPDATE,
		ST_OUT
	} state_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic prune;
		logic update;
		logic out_set;
	} cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic is_tick;
		logic last_slot;
	} stat_t;

	localparam logic [11:0] MIN_FRAME_LEN = 12'd24;
	localparam logic [31:0] DECAY_GAP_US  = 32'd35000;
	localparam logic signed [7:0] PHY_RSSI_MIN = -8'sd80;
	localparam logic [31:0] PHY_CENTER_US = 32'd10000;
	localparam logic [7:0]  PHY_MIN_BURSTS = 8'd4;
	localparam logic [11:0] TDD_MIN_LEN = 12'd60;

	localparam logic [2:0] REG_RSSI  = 3'd0;
	localparam logic [2:0] REG_HOPW  = 3'd1;
	localparam logic [2:0] REG_HOPN  = 3'd2;
	localparam logic [2:0] REG_HITS  = 3'd3;
	localparam logic [2:0] REG_TOL   = 3'd4;
	localparam logic [2:0] REG_PRUNE = 3'd5;
	localparam logic [2:0] REG_HOLD  = 3'd6;

	// Bin centre by rate code (1..5)
	function automatic logic [31:0] bin_center(input logic [2:0] code);
		case (code)
			3'd1: bin_center = 32'd2000;
			3'd2: bin_center = 32'd4000;
			3'd3: bin_center = 32'd6667;
			3'd4: bin_center = 32'd10000;
			default: bin_center = 32'd20000;
		endcase
	endfunction

	function automatic logic [8:0] bin_rate(input logic [2:0] code);
		case (code)
			3'd1: bin_rate = 9'd500;
			3'd2: bin_rate = 9'd250;
			3'd3: bin_rate = 9'd150;
			3'd4: bin_rate = 9'd100;
			3'd5: bin_rate = 9'd50;
			default: bin_rate = 9'd0;
		endcase
	endfunction

	function automatic logic in_window(input logic [31:0] d, input logic [31:0] c,
			input logic [11:0] tol);
		logic [31:0] lo;
		logic [32:0] hi;
		lo = (c > {20'd0, tol}) ? c - {20'd0, tol} : 32'd0;
		hi = {1'b0, c} + {21'd0, tol};
		in_window = (d >= lo) && ({1'b0, d} <= hi);
	endfunction

endpackage

[hdl/thpt_ctrl.sv]
module thpt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output logic cfg_ready,
	output thpt_pkg::cmd_t cmd,
	input  thpt_pkg::stat_t stat
);

	thpt_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= thpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			thpt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cfg_ready = !in_valid;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = thpt_pkg::ST_SCAN;
				end
			end
			thpt_pkg::ST_SCAN: begin
				if (stat.is_tick) begin
					cmd.prune = 1'b1;
					if (stat.last_slot) state_d = thpt_pkg::ST_UPDATE;
				end else begin
					cmd.scan = 1'b1;
					if (stat.last_slot) state_d = thpt_pkg::ST_UPDATE;
				end
			end
			thpt_pkg::ST_PRUNE: state_d = thpt_pkg::ST_UPDATE;
			thpt_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				cmd.out_set = 1'b1;
				state_d = thpt_pkg::ST_OUT;
			end
			thpt_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = thpt_pkg::ST_IDLE;
			end
			default: state_d = thpt_pkg::ST_IDLE;
		endcase
	end

endmodule

[hdl/thpt_dp.sv]
module thpt_dp #(
	parameter int TRACK_SLOTS = 16,
	parameter int CHAN_LOW = 1,
	parameter int CHAN_HIGH = 13
) (
	input  logic clk,
	input  logic arst_n,
	input  thpt_pkg::cmd_t cmd,
	output thpt_pkg::stat_t stat,
	input  logic        mode,
	input  logic [47:0] src_mac,
	input  logic [3:0]  channel,
	input  logic signed [7:0] rssi,
	input  logic [31:0] time_us,
	input  logic [31:0] now_ms,
	input  logic [11:0] frame_len,
	input  logic        rx_error,
	input  logic        vendor_match,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        detected,
	output logic [3:0]  behaviour_flags,
	output logic [8:0]  rate_hz,
	output logic [3:0]  hop_count,
	output logic [2:0]  track_flags,
	output logic        tracked
);

	localparam int SW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

	// configuration registers
	logic signed [7:0] rssi_thr_q;
	logic [15:0] hop_win_q, prune_age_q, hold_time_q;
	logic [3:0]  hop_min_q;
	logic [7:0]  min_hits_q;
	logic [11:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rssi_thr_q  <= -8'sd90;
			hop_win_q   <= 16'd600;
			hop_min_q   <= 4'd3;
			min_hits_q  <= 8'd4;
			tol_q       <= 12'd200;
			prune_age_q <= 16'd2500;
			hold_time_q <= 16'd5000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thpt_pkg::REG_RSSI:  rssi_thr_q  <= cfg_data[7:0];
				thpt_pkg::REG_HOPW:  hop_win_q   <= cfg_data;
				thpt_pkg::REG_HOPN:  hop_min_q   <= cfg_data[3:0];
				thpt_pkg::REG_HITS:  min_hits_q  <= cfg_data[7:0];
				thpt_pkg::REG_TOL:   tol_q       <= cfg_data[11:0];
				thpt_pkg::REG_PRUNE: prune_age_q <= cfg_data;
				thpt_pkg::REG_HOLD:  hold_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured request
	logic        mode_q, rxerr_q, vend_q;
	logic [47:0] mac_q;
	logic [3:0]  chan_q;
	logic signed [7:0] rssi_q;
	logic [31:0] tus_q, now_q;
	logic [11:0] len_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode; mac_q <= src_mac; chan_q <= channel; rssi_q <= rssi;
			tus_q <= time_us; now_q <= now_ms; len_q <= frame_len;
			rxerr_q <= rx_error; vend_q <= vendor_match;
		end
	end

	// track table
	logic [TRACK_SLOTS-1:0] valid_q, arr_valid_q;
	logic [47:0] addr_q  [TRACK_SLOTS];
	logic [31:0] wstart_q[TRACK_SLOTS];
	logic [31:0] seen_q  [TRACK_SLOTS];
	logic [15:0] cset_q  [TRACK_SLOTS];
	logic [3:0]  ctot_q  [TRACK_SLOTS];
	logic [31:0] arr_q   [TRACK_SLOTS];
	logic [7:0]  hits_q  [TRACK_SLOTS];
	logic [2:0]  code_q  [TRACK_SLOTS];
	logic [2:0]  tfl_q   [TRACK_SLOTS];

	// scan state
	logic [SW:0] idx_q;
	logic [SW-1:0] idx;
	logic [SW-1:0] pick_q;
	logic [31:0] oldest_q;
	logic        found_q;

	assign idx = idx_q[SW-1:0];
	assign stat.is_tick = mode_q;
	assign stat.last_slot = (idx_q == (SW+1)'(TRACK_SLOTS - 1));

	logic [31:0] age;
	assign age = now_q - seen_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			found_q <= 1'b0;
			oldest_q <= '1;
			pick_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
			found_q <= 1'b0;
			oldest_q <= '1;
			pick_q <= '0;
		end else if (cmd.scan || cmd.prune) begin
			idx_q <= idx_q + 1'b1;
			if (cmd.scan && !found_q) begin
				if (valid_q[idx] && addr_q[idx] == mac_q) begin
					found_q <= 1'b1;
					pick_q <= idx;
				end else if (!valid_q[idx]) begin
					pick_q <= idx;
					oldest_q <= '0;
				end else if (seen_q[idx] < oldest_q) begin
					oldest_q <= seen_q[idx];
					pick_q <= idx;
				end
			end
		end
	end

	// frame classification
	logic above_thr, phy_run, long_frame, addr_ok, do_track;
	assign above_thr = rssi_q >= rssi_thr_q;
	assign phy_run = above_thr && rxerr_q && (rssi_q >= thpt_pkg::PHY_RSSI_MIN);
	assign long_frame = above_thr && (len_q >= thpt_pkg::MIN_FRAME_LEN);
	assign addr_ok = !(mac_q[40] || mac_q[47:24] == 24'd0);
	assign do_track = long_frame && addr_ok;

	// held detection state
	logic [3:0]  hflags_q;
	logic [8:0]  hrate_q;
	logic [3:0]  hhops_q;
	logic        hdet_q, phy_valid_q;
	logic [31:0] ldet_q, phy_last_q;
	logic [7:0]  bursts_q;

	// selected track, taken fresh if newly allocated
	logic [SW-1:0] t;
	logic        fresh;
	logic [31:0] ws0, dwin;
	logic [15:0] cs0, cs1, cmask;
	logic [3:0]  ct0, ct1;
	logic        in_rng, hop;
	logic [31:0] d;
	logic        iv;
	logic [2:0]  bcode;
	logic [7:0]  h0, h1;
	logic [2:0]  c1, f1;
	logic [3:0]  hf1;
	logic [8:0]  hr1;
	logic [3:0]  hh1;
	logic [31:0] pd;
	logic        pwin;
	logic [7:0]  pb1;

	always_comb begin
		t = pick_q;
		fresh = !found_q;
		ws0 = fresh ? now_q : wstart_q[t];
		cs0 = fresh ? 16'd0 : cset_q[t];
		ct0 = fresh ? 4'd0 : ctot_q[t];
		h0  = fresh ? 8'd0 : hits_q[t];
		c1  = fresh ? 3'd0 : code_q[t];
		f1  = fresh ? 3'd0 : tfl_q[t];
		iv  = fresh ? 1'b0 : arr_valid_q[t];
		hf1 = hflags_q; hr1 = hrate_q; hh1 = hhops_q;
		pb1 = bursts_q;
		// phy burst detector
		pd = tus_q - phy_last_q;
		pwin = thpt_pkg::in_window(pd, thpt_pkg::PHY_CENTER_US, tol_q);
		if (phy_run && phy_valid_q) begin
			if (pwin) begin
				if (pb1 != 8'hFF) pb1 = pb1 + 8'd1;
				if (pb1 >= thpt_pkg::PHY_MIN_BURSTS) begin
					hf1 = hf1 | 4'b1010;
					hr1 = 9'd100;
				end
			end else if (pd > thpt_pkg::DECAY_GAP_US) begin
				pb1 = 8'd0;
			end
		end
		// channel window
		dwin = now_q - ws0;
		if (dwin > {16'd0, hop_win_q}) begin
			ws0 = now_q; cs0 = 16'd0; ct0 = 4'd0;
		end
		in_rng = (chan_q >= 4'(CHAN_LOW)) && (chan_q <= 4'(CHAN_HIGH));
		cmask = 16'd1 << chan_q;
		cs1 = cs0; ct1 = ct0;
		if (in_rng && !(|(cs0 & cmask))) begin
			cs1 = cs0 | cmask;
			if (ct0 != 4'd15) ct1 = ct0 + 4'd1;
		end
		hop = ct1 >= hop_min_q;
		if (do_track && hop) begin
			f1 = f1 | 3'b001; hf1 = hf1 | 4'b0001; hh1 = ct1;
		end
		// interval bins
		d = tus_q - arr_q[t];
		bcode = 3'd0;
		for (int k = 5; k >= 1; k--)
			if (thpt_pkg::in_window(d, thpt_pkg::bin_center(3'(k)), tol_q)) bcode = 3'(k);
		h1 = h0;
		if (iv && tus_q > arr_q[t]) begin
			if (bcode != 3'd0) begin
				if (c1 == bcode) begin
					if (h1 != 8'hFF) h1 = h1 + 8'd1;
				end else begin
					c1 = bcode; h1 = 8'd1;
				end
				if (h1 >= min_hits_q && do_track) begin
					if (bcode == 3'd4 || (bcode == 3'd5 && len_q > thpt_pkg::TDD_MIN_LEN)) begin
						f1 = f1 | 3'b010; hf1 = hf1 | 4'b0010;
					end else begin
						f1 = f1 | 3'b100; hf1 = hf1 | 4'b0100;
					end
					hr1 = thpt_pkg::bin_rate(bcode);
				end
			end else if (d > thpt_pkg::DECAY_GAP_US) begin
				h1 = 8'd0;
			end else if (h1 != 8'd0) begin
				h1 = h1 - 8'd1;
			end
		end
	end

	// table and held state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; arr_valid_q <= '0;
			hflags_q <= '0; hrate_q <= '0; hhops_q <= '0; hdet_q <= 1'b0;
			ldet_q <= '0; phy_last_q <= '0; phy_valid_q <= 1'b0; bursts_q <= '0;
		end else if (cmd.prune) begin
			if (valid_q[idx] && age >= {16'd0, prune_age_q}) valid_q[idx] <= 1'b0;
		end else if (cmd.update) begin
			if (mode_q) begin
				if (hdet_q && (now_q - ldet_q) >= {16'd0, hold_time_q}) begin
					hdet_q <= 1'b0; hflags_q <= '0; hrate_q <= '0; hhops_q <= '0;
				end
			end else if (above_thr) begin
				hflags_q <= hf1; hrate_q <= hr1; hhops_q <= hh1; bursts_q <= pb1;
				if (phy_run) begin
					phy_last_q <= tus_q; phy_valid_q <= 1'b1;
				end
				if (do_track) begin
					valid_q[t] <= 1'b1; arr_valid_q[t] <= 1'b1;
				end
				if (long_frame && (vend_q || hf1 != 4'd0)) begin
					hdet_q <= 1'b1; ldet_q <= now_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && !mode_q && do_track) begin
			addr_q[t] <= mac_q; wstart_q[t] <= ws0; seen_q[t] <= now_q;
			cset_q[t] <= cs1; ctot_q[t] <= ct1; arr_q[t] <= tus_q;
			hits_q[t] <= h1; code_q[t] <= c1; tfl_q[t] <= f1;
		end
	end

	// result register
	logic [2:0] tf_q;
	logic       trk_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_q <= '0; trk_q <= 1'b0;
		end else if (cmd.out_set) begin
			trk_q <= !mode_q && do_track;
			tf_q <= (!mode_q && do_track) ? f1 : 3'd0;
		end
	end

	assign detected = hdet_q;
	assign behaviour_flags = hflags_q;
	assign rate_hz = hrate_q;
	assign hop_count = hhops_q;
	assign track_flags = tf_q;
	assign tracked = trk_q;

endmodule

[hdl/transmitter_hop_and_period_tracker.sv]
// Transmitter hop and period tracker.
// Each request is taken in idle; the slot scan/prune then walks one table entry a cycle,
// followed by an update step and a result step that holds until the sink takes the
// result. A new request is taken only once the block is back in idle.
// Reset (arst_n low): tracks invalid, held state clear, registers at defaults.
module transmitter_hop_and_period_tracker #(
	parameter int TRACK_SLOTS = 16,
	parameter int CHAN_LOW = 1,
	parameter int CHAN_HIGH = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [47:0] src_mac,
	input  logic [3:0]  channel,
	input  logic signed [7:0] rssi,
	input  logic [31:0] time_us,
	input  logic [31:0] now_ms,
	input  logic [11:0] frame_len,
	input  logic        rx_error,
	input  logic        vendor_match,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        detected,
	output logic [3:0]  behaviour_flags,
	output logic [8:0]  rate_hz,
	output logic [3:0]  hop_count,
	output logic [2:0]  track_flags,
	output logic        tracked
);

	thpt_pkg::cmd_t  cmd;
	thpt_pkg::stat_t stat;

	thpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cfg_ready(cfg_ready),
		.cmd(cmd), .stat(stat)
	);

	thpt_dp #(.TRACK_SLOTS(TRACK_SLOTS), .CHAN_LOW(CHAN_LOW), .CHAN_HIGH(CHAN_HIGH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.mode(mode), .src_mac(src_mac), .channel(channel), .rssi(rssi),
		.time_us(time_us), .now_ms(now_ms), .frame_len(frame_len),
		.rx_error(rx_error), .vendor_match(vendor_match),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.detected(detected), .behaviour_flags(behaviour_flags), .rate_hz(rate_hz),
		.hop_count(hop_count), .track_flags(track_flags), .tracked(tracked)
	);

endmodule

[verif/transmitter_hop_and_period_tracker_test.sv]
module transmitter_hop_and_period_tracker_test;

	localparam int SLOTS      = 16;
	localparam int CH_LO      = 1;
	localparam int CH_HI      = 13;
	localparam int CYCLE_CAP  = 600000;
	localparam logic [11:0] SHORT_LEN = 12'd24;
	localparam logic [11:0] TDD_LEN   = 12'd60;
	localparam logic [31:0] DECAY_US  = 32'd35000;
	localparam logic signed [7:0] PHY_FLOOR = -8'sd80;
	localparam logic [31:0] PHY_GAP_US = 32'd10000;
	localparam logic [7:0]  PHY_BURSTS = 8'd4;
	localparam logic [31:0] CENTRE [5] = '{32'd2000, 32'd4000, 32'd6667, 32'd10000, 32'd20000};
	localparam logic [8:0]  RATE [6]   = '{9'd0, 9'd500, 9'd250, 9'd150, 9'd100, 9'd50};

	typedef struct {
		logic        mode;
		logic [47:0] mac;
		logic [3:0]  ch;
		logic signed [7:0] rssi;
		logic [31:0] tus;
		logic [31:0] now;
		logic [11:0] len;
		logic        rxerr;
		logic        vend;
	} rx_req_t;

	typedef struct {
		logic       det;
		logic [3:0] flags;
		logic [8:0] rate;
		logic [3:0] hops;
		logic [2:0] tflags;
		logic       trk;
	} verdict_t;

	typedef struct {
		rx_req_t  r;
		bit       fixed;
		verdict_t v;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [47:0] src_mac;
	logic [3:0]  channel;
	logic signed [7:0] rssi;
	logic [31:0] time_us;
	logic [31:0] now_ms;
	logic [11:0] frame_len;
	logic        rx_error;
	logic        vendor_match;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        detected;
	logic [3:0]  behaviour_flags;
	logic [8:0]  rate_hz;
	logic [3:0]  hop_count;
	logic [2:0]  track_flags;
	logic        tracked;

	transmitter_hop_and_period_tracker dut (.*);

	// Register shadow
	logic signed [7:0] thr;
	logic [15:0] hop_win;
	logic [3:0]  hop_min;
	logic [7:0]  hits_min;
	logic [11:0] tol;
	logic [15:0] prune_age;
	logic [15:0] hold_ms;

	// Track table shadow
	logic        t_v [SLOTS];
	logic [47:0] t_mac [SLOTS];
	logic [31:0] t_ws [SLOTS];
	logic [31:0] t_seen [SLOTS];
	logic [15:0] t_set [SLOTS];
	logic [3:0]  t_tot [SLOTS];
	logic [31:0] t_arr [SLOTS];
	logic        t_arr_v [SLOTS];
	logic [7:0]  t_hits [SLOTS];
	logic [2:0]  t_code [SLOTS];
	logic [2:0]  t_flags [SLOTS];

	logic [3:0]  h_flags;
	logic [8:0]  h_rate;
	logic [3:0]  h_hops;
	logic        h_det;
	logic [31:0] last_det;
	logic [31:0] phy_last;
	logic        phy_v;
	logic [7:0]  phy_cnt;

	verdict_t pending_q [$];
	bit       failed = 1'b0;
	bit       calm;
	int       cycles = 0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("transmitter_hop_and_period_tracker_test failed");
			$finish;
		end
	end

	// Sink side back-pressure
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 19);
	end

	function automatic logic near(input logic [31:0] d, input logic [31:0] c);
		logic [32:0] lo;
		logic [32:0] hi;
		lo = (c > {20'd0, tol}) ? {1'b0, c - {20'd0, tol}} : 33'd0;
		hi = {1'b0, c} + {21'd0, tol};
		return ({1'b0, d} >= lo) && ({1'b0, d} <= hi);
	endfunction

	function automatic void reset_shadow();
		for (int i = 0; i < SLOTS; i++) begin
			t_v[i] = 0; t_mac[i] = 0; t_ws[i] = 0; t_seen[i] = 0; t_set[i] = 0;
			t_tot[i] = 0; t_arr[i] = 0; t_arr_v[i] = 0; t_hits[i] = 0;
			t_code[i] = 0; t_flags[i] = 0;
		end
		thr = -8'sd90; hop_win = 16'd600; hop_min = 4'd3; hits_min = 8'd4;
		tol = 12'd200; prune_age = 16'd2500; hold_ms = 16'd5000;
		h_flags = 0; h_rate = 0; h_hops = 0; h_det = 0; last_det = 0;
		phy_last = 0; phy_v = 0; phy_cnt = 0;
	endfunction

	// Advance the shadow by one request and return the result it should give
	function automatic verdict_t predict(input rx_req_t r);
		verdict_t    v;
		int          pick;
		bit          found;
		logic [31:0] oldest;
		logic [31:0] d;
		logic [2:0]  code;
		logic [15:0] m;
		v = '{default: 0};
		if (r.mode) begin
			for (int i = 0; i < SLOTS; i++)
				if (t_v[i] && (r.now - t_seen[i]) >= {16'd0, prune_age})
					t_v[i] = 0;
			if (h_det && (r.now - last_det) >= {16'd0, hold_ms}) begin
				h_det = 0; h_flags = 0; h_rate = 0; h_hops = 0;
			end
		end else if (r.rssi >= thr) begin
			// PHY error burst detector
			if (r.rxerr && r.rssi >= PHY_FLOOR) begin
				if (phy_v) begin
					d = r.tus - phy_last;
					if (near(d, PHY_GAP_US)) begin
						if (phy_cnt != 8'hFF) phy_cnt++;
						if (phy_cnt >= PHY_BURSTS) begin
							h_flags |= 4'b1010;
							h_rate = 9'd100;
						end
					end else if (d > DECAY_US)
						phy_cnt = 0;
				end
				phy_last = r.tus;
				phy_v = 1;
			end
			if (r.len >= SHORT_LEN) begin
				if (!(r.mac[40] || r.mac[47:24] == 24'd0)) begin
					// slot lookup or allocation
					pick = 0; found = 0; oldest = 32'hFFFF_FFFF;
					for (int i = 0; i < SLOTS; i++) begin
						if (!found) begin
							if (t_v[i] && t_mac[i] == r.mac) begin
								pick = i; found = 1;
							end else if (!t_v[i]) begin
								pick = i; oldest = 0;
							end else if (t_seen[i] < oldest) begin
								oldest = t_seen[i]; pick = i;
							end
						end
					end
					if (!found) begin
						t_set[pick] = 0; t_tot[pick] = 0; t_arr[pick] = 0; t_arr_v[pick] = 0;
						t_hits[pick] = 0; t_code[pick] = 0; t_flags[pick] = 0;
						t_mac[pick] = r.mac; t_ws[pick] = r.now; t_seen[pick] = r.now;
						t_v[pick] = 1;
					end
					// hop window
					if ((r.now - t_ws[pick]) > {16'd0, hop_win}) begin
						t_ws[pick] = r.now; t_set[pick] = 0; t_tot[pick] = 0;
					end
					if (r.ch >= CH_LO && r.ch <= CH_HI) begin
						m = 16'd1 << r.ch;
						if ((t_set[pick] & m) == 0) begin
							t_set[pick] |= m;
							if (t_tot[pick] != 4'hF) t_tot[pick]++;
						end
					end
					if (t_tot[pick] >= hop_min) begin
						t_flags[pick] |= 3'b001;
						h_flags |= 4'b0001;
						h_hops = t_tot[pick];
					end
					// interval bins
					if (t_arr_v[pick] && r.tus > t_arr[pick]) begin
						d = r.tus - t_arr[pick];
						code = 0;
						for (int k = 0; k < 5; k++)
							if (code == 0 && near(d, CENTRE[k])) code = 3'(k + 1);
						if (code != 0) begin
							if (t_code[pick] == code) begin
								if (t_hits[pick] != 8'hFF) t_hits[pick]++;
							end else begin
								t_code[pick] = code; t_hits[pick] = 1;
							end
							if (t_hits[pick] >= hits_min) begin
								if (code == 3'd4 || (code == 3'd5 && r.len > TDD_LEN)) begin
									t_flags[pick] |= 3'b010; h_flags |= 4'b0010;
								end else begin
									t_flags[pick] |= 3'b100; h_flags |= 4'b0100;
								end
								h_rate = RATE[code];
							end
						end else if (d > DECAY_US)
							t_hits[pick] = 0;
						else if (t_hits[pick] != 0)
							t_hits[pick]--;
					end
					t_arr[pick] = r.tus; t_arr_v[pick] = 1; t_seen[pick] = r.now;
					v.tflags = t_flags[pick];
					v.trk = 1;
				end
				if (r.vend || h_flags != 0) begin
					h_det = 1; last_det = r.now;
				end
			end
		end
		v.det = h_det; v.flags = h_flags; v.rate = h_rate; v.hops = h_hops;
		return v;
	endfunction

	function automatic rx_req_t mk(input logic md, input logic [47:0] mac, input logic [3:0] ch,
			input logic signed [7:0] rs, input logic [31:0] tus, input logic [31:0] now,
			input logic [11:0] len, input logic rxe, input logic vd);
		rx_req_t r;
		r.mode = md; r.mac = mac; r.ch = ch; r.rssi = rs; r.tus = tus; r.now = now;
		r.len = len; r.rxerr = rxe; r.vend = vd;
		return r;
	endfunction

	// Result checker: sampled mid-cycle, taken at the following rising edge
	always @(negedge clk) begin
		verdict_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("result with no request outstanding");
				failed = 1;
			end else begin
				w = pending_q.pop_front();
				if (detected !== w.det) begin
					$error("detected: expected %0d got %0d", w.det, detected); failed = 1;
				end
				if (behaviour_flags !== w.flags) begin
					$error("behaviour_flags: expected %0h got %0h", w.flags, behaviour_flags);
					failed = 1;
				end
				if (rate_hz !== w.rate) begin
					$error("rate_hz: expected %0d got %0d", w.rate, rate_hz); failed = 1;
				end
				if (hop_count !== w.hops) begin
					$error("hop_count: expected %0d got %0d", w.hops, hop_count); failed = 1;
				end
				if (track_flags !== w.tflags) begin
					$error("track_flags: expected %0h got %0h", w.tflags, track_flags); failed = 1;
				end
				if (tracked !== w.trk) begin
					$error("tracked: expected %0d got %0d", w.trk, tracked); failed = 1;
				end
			end
		end
	end

	// Present one request and hold it until taken
	task automatic send(input rx_req_t r, input bit fixed, input verdict_t typed);
		verdict_t p;
		in_valid <= 1'b1;
		mode <= r.mode; src_mac <= r.mac; channel <= r.ch; rssi <= r.rssi;
		time_us <= r.tus; now_ms <= r.now; frame_len <= r.len;
		rx_error <= r.rxerr; vendor_match <= r.vend;
		forever begin
			@(negedge clk);
			if (!in_stall) break;
			@(posedge clk);
		end
		@(posedge clk);
		p = predict(r);
		pending_q.push_back(fixed ? typed : p);
		if (!calm && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Wait out every result, then the block's tail
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
			@(posedge clk);
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			thpt_pkg::REG_RSSI:  thr = signed'(val[7:0]);
			thpt_pkg::REG_HOPW:  hop_win = val;
			thpt_pkg::REG_HOPN:  hop_min = val[3:0];
			thpt_pkg::REG_HITS:  hits_min = val[7:0];
			thpt_pkg::REG_TOL:   tol = val[11:0];
			thpt_pkg::REG_PRUNE: prune_age = val;
			thpt_pkg::REG_HOLD:  hold_ms = val;
			default: ;
		endcase
	endtask

	task automatic setup(input logic signed [7:0] a, input logic [15:0] b, input logic [3:0] c,
			input logic [7:0] e, input logic [11:0] f, input logic [15:0] g, input logic [15:0] h);
		write_reg(thpt_pkg::REG_RSSI, {8'h00, a});
		write_reg(thpt_pkg::REG_HOPW, b);
		write_reg(thpt_pkg::REG_HOPN, {12'd0, c});
		write_reg(thpt_pkg::REG_HITS, {8'd0, e});
		write_reg(thpt_pkg::REG_TOL, {4'd0, f});
		write_reg(thpt_pkg::REG_PRUNE, g);
		write_reg(thpt_pkg::REG_HOLD, h);
	endtask

	initial begin
		row_t        plan [$];
		verdict_t    zero;
		verdict_t    none;
		rx_req_t     r;
		logic [47:0] pool [20];
		logic [31:0] pool_us [20];
		int          pool_bin [20];
		logic [31:0] cur_ms;
		logic [31:0] phy_t;
		logic [47:0] mac_a;
		int          k;
		int          sel;
		int          n;

		arst_n = 1'b0; in_valid = 0; mode = 0; src_mac = 0; channel = 0; rssi = 0;
		time_us = 0; now_ms = 0; frame_len = 0; rx_error = 0; vendor_match = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		calm = 0;
		reset_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at reset settings
		zero = '{default: 0};
		none = '{default: 0};
		mac_a = 48'h02_1A_2B_3C_4D_5E;
		plan.push_back('{mk(1, 48'h0, 0, 0, 0, 0, 0, 0, 0), 1, zero});
		plan.push_back('{mk(0, mac_a, 1, -8'sd128, 0, 5, 100, 1, 1), 1, zero});
		plan.push_back('{mk(0, 48'h00_00_00_12_34_56, 2, -8'sd40, 7, 6, 200, 0, 0), 1, zero});
		plan.push_back('{mk(0, 48'hFF_FF_FF_FF_FF_FF, 15, 8'sd127, 9, 7, 4095, 0, 0), 1, zero});
		plan.push_back('{mk(0, mac_a, 3, -8'sd50, 11, 8, 23, 0, 1), 1, zero});
		plan.push_back('{mk(0, mac_a, 1, -8'sd50, 0, 100, 24, 0, 0), 1,
			'{1'b0, 4'd0, 9'd0, 4'd0, 3'd0, 1'b1}});
		plan.push_back('{mk(0, mac_a, 5, -8'sd50, 2000, 101, 80, 0, 0), 0, none});
		plan.push_back('{mk(0, mac_a, 13, -8'sd50, 4000, 102, 80, 0, 0), 0, none});
		plan.push_back('{mk(0, mac_a, 0, -8'sd50, 6000, 103, 80, 0, 0), 0, none});
		plan.push_back('{mk(0, mac_a, 14, -8'sd50, 8000, 104, 80, 0, 0), 0, none});
		plan.push_back('{mk(0, mac_a, 14, -8'sd50, 8000, 105, 80, 0, 0), 0, none});
		plan.push_back('{mk(0, mac_a, 7, -8'sd50, 7000, 106, 80, 0, 0), 0, none});
		plan.push_back('{mk(0, 48'h0A_0B_0C_0D_0E_0F, 9, -8'sd60, 50, 110, 300, 0, 1), 0, none});
		for (int i = 0; i < 5; i++)
			plan.push_back('{mk(0, 48'h01_00_00_00_00_01, 6, -8'sd80, 32'd50000 + i * 10000,
				120 + i, 100, 1, 0), 0, none});
		plan.push_back('{mk(1, 48'h0, 0, 0, 0, 3000, 0, 0, 0), 0, none});
		plan.push_back('{mk(1, 48'h0, 0, 0, 0, 9000, 0, 0, 0), 0, none});
		plan.push_back('{mk(0, mac_a, 4, -8'sd89, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1, 1),
			0, none});
		foreach (plan[i]) send(plan[i].r, plan[i].fixed, plan[i].v);
		drain();

		// Random traffic over several register settings
		cur_ms = $urandom;
		phy_t = $urandom;
		for (int i = 0; i < 20; i++) begin
			pool[i] = 48'({$urandom, $urandom});
			pool[i][40] = 1'b0;
			pool[i][41] = 1'b1;
			pool_us[i] = $urandom;
			pool_bin[i] = $urandom_range(0, 4);
		end
		pool[18][40] = 1'b1;
		pool[19][47:24] = 24'd0;
		n = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: setup(-8'sd128, 16'd1, 4'd1, 8'd1, 12'd0, 16'd1, 16'd1);
				2: setup(8'sd0, 16'hFFFF, 4'd13, 8'd255, 12'd4095, 16'hFFFF, 16'hFFFF);
				3: setup(-8'sd90, 16'd600, 4'd3, 8'd4, 12'd200, 16'd2500, 16'd5000);
				4: setup(8'(32'd0 - $urandom_range(20, 100)), 16'($urandom_range(50, 2000)),
					4'($urandom_range(1, 13)), 8'($urandom_range(1, 8)),
					12'($urandom_range(0, 400)), 16'($urandom_range(200, 4000)),
					16'($urandom_range(200, 8000)));
				default: ;
			endcase
			for (int j = 0; j < 120; j++) begin
				calm = (n >= 250 && n < 340);
				n++;
				r = mk(0, 48'({$urandom, $urandom}), 4'($urandom_range(0, 15)),
					8'($urandom_range(0, 255)), $urandom, 0, 12'($urandom_range(0, 4095)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 99) < 8) begin
					// housekeeping tick, occasionally after a long quiet spell
					r.mode = 1;
					cur_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(1000, 8000)
						: $urandom_range(0, 50);
				end else begin
					k = $urandom_range(0, 19);
					if ($urandom_range(0, 99) >= 5) r.mac = pool[k];
					cur_ms += ($urandom_range(0, 99) < 3) ? $urandom_range(700, 7000)
						: $urandom_range(0, 20);
					sel = $urandom_range(0, 9);
					if (sel < 7)
						pool_us[k] += CENTRE[(sel == 0) ? $urandom_range(0, 4) : pool_bin[k]]
							+ $urandom_range(0, 300) - 150;
					else if (sel == 7)
						pool_us[k] += $urandom_range(36000, 100000);
					else if (sel == 8)
						pool_us[k] -= $urandom_range(0, 5000);
					else
						pool_us[k] = $urandom;
					r.tus = pool_us[k];
					r.rxerr = ($urandom_range(0, 99) < 15);
					if (r.rxerr) begin
						phy_t += ($urandom_range(0, 9) == 0) ? $urandom
							: 32'd10000 + $urandom_range(0, 300) - 150;
						r.tus = phy_t;
					end
					if ($urandom_range(0, 99) < 80) r.rssi = 8'($urandom_range(0, 127) - 80);
					if ($urandom_range(0, 99) < 85) r.len = 12'($urandom_range(24, 4095));
					else r.len = 12'($urandom_range(0, 23));
					r.vend = ($urandom_range(0, 99) < 4);
				end
				r.now = cur_ms;
				send(r, 0, none);
			end
			drain();
		end
		calm = 0;

		if (pending_q.size() != 0)
			$error("%0d results never arrived", pending_q.size());
		if (!failed && pending_q.size() == 0)
			$display("transmitter_hop_and_period_tracker_test passed");
		else
			$display("transmitter_hop_and_period_tracker_test failed");
		$finish;
	end

endmodule
